[design/mm_pkg.sv]
package mm_pkg;

    // Field widths
    localparam int MODE_W     = 2;
    localparam int IDX_W      = 3;
    localparam int ELEM_W     = 32;
    localparam int PROD_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_LOAD_LEFT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLS = 2'd3;

    // Sequencer to multiply-accumulate unit
    typedef struct packed {
        logic clear;     // start a new dot product
        logic rd_valid;  // operand pair present on the store read ports
    } t_mac_ctrl;

endpackage

[design/mm_cfg_if.sv]
interface mm_cfg_if import mm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/mm_in_if.sv]
interface mm_in_if import mm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element;

    modport source (output valid, output mode, output row_index, output col_index,
                    output element, input ready);
    modport sink   (input valid, input mode, input row_index, input col_index,
                    input element, output ready);
endinterface

[design/mm_out_if.sv]
interface mm_out_if import mm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [PROD_W-1:0] product;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     size_error;
    logic                     last;

    modport source (output valid, output product, output out_row, output out_col,
                    output size_error, output last, input ready);
    modport sink   (input valid, input product, input out_row, input out_col,
                    input size_error, input last, output ready);
endinterface

[design/matrix_multiply.sv]
// Matrix multiply on signed Q16.16 elements, products given as saturated Q32.32.
// Channels:
//   i_cfg    - register writes; index 0..3 selects left_rows, left_cols,
//              right_rows, right_cols. Always ready; write only when idle.
//   i_item   - one transfer per item. Mode 0 and 1 load one left or right
//              element at (row_index, col_index); loads are taken one per
//              cycle while idle and give no result. Mode 2 starts a compute.
//   o_result - product elements in row-major order, last set on the final
//              one; a single result with size_error and last set when
//              left_cols differs from right_rows.
// Datapath: one shared multiplier and accumulator work through one multiply
//   per cycle: store read, registered product, accumulate, then a drain of
//   the pipeline and the hand-over of the element to the output register.
// i_item.ready is low for the whole compute. A stalled receiver holds the
//   result in the output register; the sequencer waits on it before handing
//   over the next element. An error result is loaded into the output
//   register from the S_ERR state once the output register is free.
// Reset: all four dimension registers return to 1 and the output empties.
//   Store contents are not cleared; read only entries that have been loaded.
module matrix_multiply import mm_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mm_cfg_if.sink          i_cfg,
    mm_in_if.sink           i_item,
    mm_out_if.source        o_result
);

    localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W  = 2 * ELEM_W + $clog2(MAX_DIM) + 1;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;

    // Effective dimension minus one: zero counts as one, clamp at MAX_DIM
    function automatic logic [DIM_W-1:0] eff_m1(input logic [CFG_DATA_W-1:0] v);
        logic [CFG_DATA_W:0] w;
        w = {1'b0, v};
        if (v == '0) begin
            return '0;
        end else if (w > (CFG_DATA_W+1)'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM - 1);
        end else begin
            return DIM_W'(w - 1'b1);
        end
    endfunction

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_left_rows, r_left_cols, r_right_rows, r_right_cols;

    // Sequencer
    logic [2:0]       r_state, n_state;
    logic [DIM_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [DIM_W-1:0] r_rows_m1, n_rows_m1, r_cols_m1, n_cols_m1, r_n_m1, n_n_m1;
    logic             r_rd_v;

    // Output register
    logic                     r_out_valid, n_out_valid;
    logic signed [PROD_W-1:0] r_out_product, n_out_product;
    logic [IDX_W-1:0]         r_out_row, n_out_row, r_out_col, n_out_col;
    logic                     r_out_err, n_out_err, r_out_last, n_out_last;

    logic                     item_acc, cfg_acc, in_range, slot_free, elem_last;
    logic                     we_left, we_right;
    logic [ADDR_W-1:0]        waddr, raddr_left, raddr_right;
    logic [ELEM_W-1:0]        rd_left, rd_right;
    t_mac_ctrl                mac_ctrl;
    logic                     mac_busy;
    logic signed [PROD_W-1:0] mac_sum;

    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_rows  <= CFG_DATA_W'(1);
            r_left_cols  <= CFG_DATA_W'(1);
            r_right_rows <= CFG_DATA_W'(1);
            r_right_cols <= CFG_DATA_W'(1);
        end else if (cfg_acc) begin
            case (i_cfg.index)
                CFG_LEFT_ROWS:  r_left_rows  <= i_cfg.data;
                CFG_LEFT_COLS:  r_left_cols  <= i_cfg.data;
                CFG_RIGHT_ROWS: r_right_rows <= i_cfg.data;
                CFG_RIGHT_COLS: r_right_cols <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Loads: drop any whose coordinates fall outside the store
    assign i_item.ready = (r_state == S_IDLE);
    assign item_acc     = i_item.valid && i_item.ready;
    assign in_range     = ({2'b00, i_item.row_index} < (IDX_W+2)'(MAX_DIM)) &&
                          ({2'b00, i_item.col_index} < (IDX_W+2)'(MAX_DIM));
    assign we_left      = item_acc && in_range && (i_item.mode == MODE_LOAD_LEFT);
    assign we_right     = item_acc && in_range && (i_item.mode == MODE_LOAD_RIGHT);
    assign waddr        = ADDR_W'(int'(i_item.row_index) * MAX_DIM + int'(i_item.col_index));

    // Walk row i of the left matrix and column j of the right one
    assign raddr_left  = ADDR_W'(int'(r_i) * MAX_DIM + int'(r_k));
    assign raddr_right = ADDR_W'(int'(r_k) * MAX_DIM + int'(r_j));

    mm_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_left_store (
        .i_clk   (i_clk),
        .i_we    (we_left),
        .i_waddr (waddr),
        .i_wdata (i_item.element),
        .i_raddr (raddr_left),
        .o_rdata (rd_left)
    );

    mm_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_right_store (
        .i_clk   (i_clk),
        .i_we    (we_right),
        .i_waddr (waddr),
        .i_wdata (i_item.element),
        .i_raddr (raddr_right),
        .o_rdata (rd_right)
    );

    assign mac_ctrl.clear    = (r_state == S_ISSUE) && (r_k == '0);
    assign mac_ctrl.rd_valid = r_rd_v;

    mm_mac #(.ACC_W(ACC_W)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_left  (rd_left),
        .i_right (rd_right),
        .o_busy  (mac_busy),
        .o_sum   (mac_sum)
    );

    assign slot_free = !r_out_valid || o_result.ready;
    assign elem_last = (r_i == r_rows_m1) && (r_j == r_cols_m1);

    always_comb begin
        n_state       = r_state;
        n_i           = r_i;
        n_j           = r_j;
        n_k           = r_k;
        n_rows_m1     = r_rows_m1;
        n_cols_m1     = r_cols_m1;
        n_n_m1        = r_n_m1;
        n_out_valid   = r_out_valid && !o_result.ready;
        n_out_product = r_out_product;
        n_out_row     = r_out_row;
        n_out_col     = r_out_col;
        n_out_err     = r_out_err;
        n_out_last    = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (item_acc && (i_item.mode == MODE_COMPUTE)) begin
                    if (r_left_cols != r_right_rows) begin
                        n_state = S_ERR;
                    end else begin
                        n_rows_m1 = eff_m1(r_left_rows);
                        n_cols_m1 = eff_m1(r_right_cols);
                        n_n_m1    = eff_m1(r_left_cols);
                        n_i       = '0;
                        n_j       = '0;
                        n_k       = '0;
                        n_state   = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                // Issue one operand pair a cycle
                if (r_k == r_n_m1) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                // Wait for the last product to land in the accumulator
                if (!r_rd_v && !mac_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid   = 1'b1;
                    n_out_product = mac_sum;
                    n_out_row     = IDX_W'(r_i);
                    n_out_col     = IDX_W'(r_j);
                    n_out_err     = 1'b0;
                    n_out_last    = elem_last;
                    if (elem_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = '0;
                        n_state = S_ISSUE;
                        if (r_j == r_cols_m1) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end
            end
            S_ERR: begin
                if (slot_free) begin
                    n_out_valid   = 1'b1;
                    n_out_product = '0;
                    n_out_row     = '0;
                    n_out_col     = '0;
                    n_out_err     = 1'b1;
                    n_out_last    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_rows_m1   <= '0;
            r_cols_m1   <= '0;
            r_n_m1      <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_rows_m1   <= n_rows_m1;
            r_cols_m1   <= n_cols_m1;
            r_n_m1      <= n_n_m1;
            r_rd_v      <= (r_state == S_ISSUE);
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_out_product <= n_out_product;
        r_out_row     <= n_out_row;
        r_out_col     <= n_out_col;
        r_out_err     <= n_out_err;
        r_out_last    <= n_out_last;
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.product    = r_out_product;
    assign o_result.out_row    = r_out_row;
    assign o_result.out_col    = r_out_col;
    assign o_result.size_error = r_out_err;
    assign o_result.last       = r_out_last;

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.size_error) |->
            (o_result.last && (o_result.product == '0) &&
             (o_result.out_row == '0) && (o_result.out_col == '0)))
        else $error("error result carries a malformed payload");

    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (!r_rd_v && !mac_busy))
        else $error("product handed over before the pipeline drained");

    a_compute_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_acc && (i_item.mode == MODE_COMPUTE) && (r_left_cols == r_right_rows))
            |=> ((r_state == S_ISSUE) && (r_i == '0) && (r_j == '0) && (r_k == '0)))
        else $error("compute did not start at the first element");

endmodule

[design/mm_store.sv]
module mm_store import mm_pkg::*; #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [ELEM_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [ELEM_W-1:0] o_rdata
);

    logic [ELEM_W-1:0] r_mem [DEPTH];
    logic [ELEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/mm_mac.sv]
module mm_mac import mm_pkg::*; #(
    parameter int ACC_W = 69
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctrl                i_ctrl,
    input  logic signed [ELEM_W-1:0] i_left,
    input  logic signed [ELEM_W-1:0] i_right,
    output logic                     o_busy,
    output logic signed [PROD_W-1:0] o_sum
);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_v;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ACC_W-PROD_W:0]    acc_top;

    // Register the product before it reaches the adder
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_left) * PROD_W'(i_right);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_prod_v <= i_ctrl.rd_valid;
            if (i_ctrl.clear) begin
                r_acc <= '0;
            end else if (r_prod_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // Clamp the exact sum to the signed 64-bit range
    assign acc_top = r_acc[ACC_W-1:PROD_W-1];

    always_comb begin
        if ((&acc_top) || !(|acc_top)) begin
            o_sum = r_acc[PROD_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            o_sum = {1'b1, {(PROD_W-1){1'b0}}};
        end else begin
            o_sum = {1'b0, {(PROD_W-1){1'b1}}};
        end
    end

    assign o_busy = r_prod_v;

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |-> !r_prod_v)
        else $error("accumulator cleared while a product is in flight");

    a_sign_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sum[PROD_W-1] == r_acc[ACC_W-1])
        else $error("saturated sum changed sign");

    a_exact_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&acc_top) || !(|acc_top)) |-> (o_sum == r_acc[PROD_W-1:0]))
        else $error("in-range sum was altered");

endmodule
